FILE: hdl/icfd_pkg.sv
// icfd_pkg: types, identifiers and constant tables of the imu can frame decoder
// no dependencies; used by the decoder top level and its checker
`default_nettype none

package icfd_pkg;

  localparam int DEF_CORDIC_STEPS = 16;
  localparam int DEF_FRAC_BITS    = 16;

  localparam int ANG_FRAC = 24;

  localparam logic [10:0] ID_QUAT     = 11'h401;
  localparam logic [10:0] ID_RATE     = 11'h402;
  localparam logic [10:0] ID_ACCEL    = 11'h403;
  localparam logic [10:0] ID_MAGNET   = 11'h404;
  localparam logic [10:0] ID_SETTINGS = 11'h405;

  localparam logic [3:0] LEN_QUAT  = 4'd8;
  localparam logic [3:0] LEN_EULER = 4'd6;

  localparam logic [3:0] RATE_CODE_MAX  = 4'd4;
  localparam logic [3:0] ACCEL_CODE_MAX = 4'd3;

  localparam logic signed [33:0] ASIN_ONE_S  = 34'sd50000000;
  localparam logic [51:0]        ASIN_ONE_SQ = 52'd2500000000000000;

  localparam logic signed [34:0] DEG90_Z  = 35'sd90 <<< ANG_FRAC;
  localparam logic signed [34:0] DEG180_Z = 35'sd180 <<< ANG_FRAC;

  localparam logic signed [47:0] NORM_LIMIT  = 48'sd1 <<< 40;
  localparam logic signed [47:0] COARSE_LIMIT = 48'sd1 <<< 36;

  typedef enum logic [2:0] {
    KIND_SETTINGS,
    KIND_QUAT,
    KIND_EULER,
    KIND_RATE,
    KIND_ACCEL,
    KIND_MAGNET,
    KIND_IGNORED
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_LOAD,
    ST_NORM,
    ST_ROT,
    ST_FIN,
    ST_DONE
  } state_e;

  function automatic logic [24:0] rate_scale(input logic [2:0] sel);
    logic [24:0] r;
    case (sel)
      3'd1:    r = 25'd4575276;
      3'd2:    r = 25'd2287638;
      3'd3:    r = 25'd1143819;
      3'd4:    r = 25'd571909;
      3'd5:    r = 25'd285955;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [24:0] accel_scale(input logic [2:0] sel);
    logic [24:0] r;
    case (sel)
      3'd1:    r = 25'd3854458;
      3'd2:    r = 25'd7707034;
      3'd3:    r = 25'd15414067;
      3'd4:    r = 25'd30828134;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [30:0] atan_deg(input logic [4:0] idx);
    logic [30:0] r;
    case (idx)
      5'd0:    r = 31'd754974720;
      5'd1:    r = 31'd445687602;
      5'd2:    r = 31'd235489088;
      5'd3:    r = 31'd119537938;
      5'd4:    r = 31'd60000934;
      5'd5:    r = 31'd30029717;
      5'd6:    r = 31'd15018523;
      5'd7:    r = 31'd7509720;
      5'd8:    r = 31'd3754917;
      5'd9:    r = 31'd1877466;
      5'd10:   r = 31'd938734;
      5'd11:   r = 31'd469367;
      5'd12:   r = 31'd234684;
      5'd13:   r = 31'd117342;
      5'd14:   r = 31'd58671;
      5'd15:   r = 31'd29335;
      5'd16:   r = 31'd14668;
      5'd17:   r = 31'd7334;
      5'd18:   r = 31'd3667;
      5'd19:   r = 31'd1833;
      5'd20:   r = 31'd917;
      5'd21:   r = 31'd458;
      5'd22:   r = 31'd229;
      5'd23:   r = 31'd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/imu_can_frame_decoder_unit.sv
// imu_can_frame_decoder_unit: frame decode, sensor scaling and quaternion to euler cordic
// depends on icfd_pkg for identifiers, tables and state types
`default_nettype none

// usage
// - input channel: one received can frame per transaction (id, length, eight bytes),
//   taken when in_valid_i is high and in_stall_o is low
// - output channel: one result per frame (kind, yaw, pitch, roll, rates, accels,
//   temperature, stamp), taken when out_valid_o is high and out_stall_i is low
// - a frame updates the stored quaternion, settings, temperature and stamp in its accept
//   cycle; then one shared multiplier forms all products, a bit-serial square root
//   follows and one shared cordic datapath runs up to three times, each a load,
//   normalize steps, CORDIC_STEPS rotations and a finish (a zero vector skips to finish)
// - in_stall_o is high from the accept until the result is written to the output
//   register, so one frame is in work at a time
// - the result sits in an output register; a new frame is taken while it waits,
//   and the next result is held back until the receiver takes the old one
// - reset clears all stored sensor state, scale selections and the output valid

module imu_can_frame_decoder_unit #(
  parameter int CORDIC_STEPS = icfd_pkg::DEF_CORDIC_STEPS,
  parameter int FRAC_BITS    = icfd_pkg::DEF_FRAC_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [10:0]         frame_id_i,
  input  wire logic [3:0]          frame_length_i,
  input  wire logic [63:0]         payload_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [2:0]               frame_kind_o,
  output logic [24:0]              yaw_angle_o,
  output logic signed [23:0]       pitch_angle_o,
  output logic signed [24:0]       roll_angle_o,
  output logic signed [22:0]       rate_x_o,
  output logic signed [22:0]       rate_y_o,
  output logic signed [22:0]       rate_z_o,
  output logic signed [24:0]       accel_x_o,
  output logic signed [24:0]       accel_y_o,
  output logic signed [24:0]       accel_z_o,
  output logic signed [10:0]       sensor_temp_o,
  output logic [15:0]              sensor_stamp_o
);

  localparam int SC_SH  = 32 - FRAC_BITS;
  localparam int ANG_SH = icfd_pkg::ANG_FRAC - FRAC_BITS;
  localparam logic signed [55:0] SC_HALF  = 56'sd1 <<< (SC_SH - 1);
  localparam logic signed [34:0] ANG_HALF = 35'sd1 <<< (ANG_SH - 1);
  localparam logic signed [34:0] OUT90    = 35'sd90 <<< FRAC_BITS;
  localparam logic signed [34:0] OUT180   = 35'sd180 <<< FRAC_BITS;
  localparam logic signed [34:0] OUT360   = 35'sd360 <<< FRAC_BITS;
  localparam logic [4:0] MUL_LAST  = 5'd13;
  localparam logic [4:0] SQRT_LAST = 5'd25;
  localparam logic [4:0] ROT_LAST  = 5'(CORDIC_STEPS - 1);

  icfd_pkg::state_e state_q, state_d;
  logic [4:0] step_q, step_d;
  logic [1:0] run_q, run_d;

  logic [15:0] quat_q [4];
  logic [15:0] quat_d [4];
  logic euler_mode_q, euler_mode_d;
  logic [2:0] rate_sel_q, rate_sel_d, accel_sel_q, accel_sel_d;
  logic [10:0] temp_q, temp_d;
  logic [15:0] stamp_q, stamp_d;

  icfd_pkg::kind_e kind_q, kind_d;
  logic scale_q, scale_d, rate_flag_q, rate_flag_d;
  logic [15:0] words_q [3];
  logic [15:0] words_d [3];
  logic [24:0] sen_q, sen_d;

  logic signed [22:0] rate_val_q [3];
  logic signed [22:0] rate_val_d [3];
  logic signed [24:0] accel_val_q [3];
  logic signed [24:0] accel_val_d [3];

  logic signed [27:0] mul_a, mul_b;
  logic signed [55:0] prod_q, prod_d;
  logic signed [33:0] p34;
  logic signed [55:0] sc_sum, sc_val;

  logic signed [33:0] yy_q, yy_d, yx_q, yx_d, ps_q, ps_d, ry_q, ry_d, rx_q, rx_d;
  logic [51:0] rad_q, rad_d, root_q, root_d, sq_bit, sq_trial;

  logic signed [47:0] cx_q, cx_d, cy_q, cy_d, x_in, y_in, ax, ay, dx, dy;
  logic signed [34:0] cz_q, cz_d, zc, fr, yaw_t;
  logic signed [34:0] yaw_q, yaw_d, pitch_q, pitch_d, roll_q, roll_d;
  logic signed [34:0] atan_v;

  logic out_valid_q, out_valid_d;
  logic [2:0] kind_o_q, kind_o_d;
  logic [24:0] yaw_o_q, yaw_o_d;
  logic signed [23:0] pitch_o_q, pitch_o_d;
  logic signed [24:0] roll_o_q, roll_o_d;
  logic signed [22:0] rate_o_q [3];
  logic signed [22:0] rate_o_d [3];
  logic signed [24:0] accel_o_q [3];
  logic signed [24:0] accel_o_d [3];
  logic [10:0] temp_o_q, temp_o_d;
  logic [15:0] stamp_o_q, stamp_o_d;

  logic signed [27:0] qx [4];
  logic signed [27:0] wx [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qx[i] = 28'($signed(quat_q[i]));
    end
    for (int i = 0; i < 3; i++) begin
      wx[i] = 28'($signed(words_q[i]));
    end
  end

  assign p34    = $signed(prod_q[33:0]);
  assign sc_sum = prod_q + SC_HALF;
  assign sc_val = sc_sum >>> SC_SH;

  assign sq_bit   = 52'd1 << {(SQRT_LAST - step_q), 1'b0};
  assign sq_trial = root_q + sq_bit;

  assign ax     = cx_q[47] ? -cx_q : cx_q;
  assign ay     = cy_q[47] ? -cy_q : cy_q;
  assign dx     = cy_q >>> step_q;
  assign dy     = cx_q >>> step_q;
  assign atan_v = $signed({4'b0, icfd_pkg::atan_deg(step_q)});

  always_comb begin
    if (cz_q > icfd_pkg::DEG180_Z) begin
      zc = icfd_pkg::DEG180_Z;
    end else if (cz_q < -icfd_pkg::DEG180_Z) begin
      zc = -icfd_pkg::DEG180_Z;
    end else begin
      zc = cz_q;
    end
    fr    = (zc + ANG_HALF) >>> ANG_SH;
    yaw_t = fr + OUT180;
  end

  always_comb begin
    case (run_q)
      2'd0: begin
        y_in = 48'(yy_q);
        x_in = 48'(yx_q);
      end
      2'd1: begin
        y_in = 48'(ps_q);
        x_in = $signed({22'b0, root_q[25:0]});
      end
      default: begin
        y_in = 48'(ry_q);
        x_in = 48'(rx_q);
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    run_d = run_q;
    quat_d = quat_q;
    euler_mode_d = euler_mode_q;
    rate_sel_d = rate_sel_q;
    accel_sel_d = accel_sel_q;
    temp_d = temp_q;
    stamp_d = stamp_q;
    kind_d = kind_q;
    scale_d = scale_q;
    rate_flag_d = rate_flag_q;
    words_d = words_q;
    sen_d = sen_q;
    rate_val_d = rate_val_q;
    accel_val_d = accel_val_q;
    prod_d = prod_q;
    yy_d = yy_q;
    yx_d = yx_q;
    ps_d = ps_q;
    ry_d = ry_q;
    rx_d = rx_q;
    rad_d = rad_q;
    root_d = root_q;
    cx_d = cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    yaw_d = yaw_q;
    pitch_d = pitch_q;
    roll_d = roll_q;
    out_valid_d = out_valid_q;
    kind_o_d = kind_o_q;
    yaw_o_d = yaw_o_q;
    pitch_o_d = pitch_o_q;
    roll_o_d = roll_o_q;
    rate_o_d = rate_o_q;
    accel_o_d = accel_o_q;
    temp_o_d = temp_o_q;
    stamp_o_d = stamp_o_q;
    mul_a = '0;
    mul_b = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      icfd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = icfd_pkg::KIND_IGNORED;
          scale_d = 1'b0;
          rate_flag_d = 1'b0;
          sen_d = '0;
          for (int i = 0; i < 3; i++) begin
            words_d[i] = payload_i[16*i +: 16];
          end
          case (frame_id_i)
            icfd_pkg::ID_SETTINGS: begin
              euler_mode_d = payload_i[32];
              if (payload_i[7:4] <= icfd_pkg::RATE_CODE_MAX) begin
                rate_sel_d = 3'(payload_i[7:4]) + 3'd1;
              end
              if (payload_i[3:0] <= icfd_pkg::ACCEL_CODE_MAX) begin
                accel_sel_d = 3'(payload_i[3:0]) + 3'd1;
              end
              kind_d = icfd_pkg::KIND_SETTINGS;
            end
            icfd_pkg::ID_QUAT: begin
              if (euler_mode_q && frame_length_i == icfd_pkg::LEN_EULER) begin
                kind_d = icfd_pkg::KIND_EULER;
              end else if (!euler_mode_q && frame_length_i == icfd_pkg::LEN_QUAT) begin
                for (int i = 0; i < 4; i++) begin
                  quat_d[i] = payload_i[16*i +: 16];
                end
                kind_d = icfd_pkg::KIND_QUAT;
              end
            end
            icfd_pkg::ID_RATE: begin
              scale_d = 1'b1;
              rate_flag_d = 1'b1;
              sen_d = icfd_pkg::rate_scale(rate_sel_q);
              temp_d = {payload_i[55:48], payload_i[63:61]};
              kind_d = icfd_pkg::KIND_RATE;
            end
            icfd_pkg::ID_ACCEL: begin
              scale_d = 1'b1;
              sen_d = icfd_pkg::accel_scale(accel_sel_q);
              stamp_d = payload_i[63:48];
              kind_d = icfd_pkg::KIND_ACCEL;
            end
            icfd_pkg::ID_MAGNET: begin
              kind_d = icfd_pkg::KIND_MAGNET;
            end
            default: begin
              kind_d = icfd_pkg::KIND_IGNORED;
            end
          endcase
          step_d = '0;
          state_d = icfd_pkg::ST_MUL;
        end
      end

      icfd_pkg::ST_MUL: begin
        case (step_q)
          5'd0: begin
            mul_a = qx[0];
            mul_b = qx[3];
          end
          5'd1: begin
            mul_a = qx[1];
            mul_b = qx[2];
            yy_d = p34;
          end
          5'd2: begin
            mul_a = qx[0];
            mul_b = qx[0];
            yy_d = yy_q + p34;
          end
          5'd3: begin
            mul_a = qx[1];
            mul_b = qx[1];
            yx_d = p34 - icfd_pkg::ASIN_ONE_S;
            rx_d = p34 - icfd_pkg::ASIN_ONE_S;
          end
          5'd4: begin
            mul_a = qx[0];
            mul_b = qx[2];
            yx_d = yx_q + p34;
          end
          5'd5: begin
            mul_a = qx[1];
            mul_b = qx[3];
            ps_d = p34;
          end
          5'd6: begin
            mul_a = qx[0];
            mul_b = qx[1];
            ps_d = ps_q - p34;
          end
          5'd7: begin
            mul_a = qx[2];
            mul_b = qx[3];
            ry_d = p34;
          end
          5'd8: begin
            mul_a = qx[3];
            mul_b = qx[3];
            ry_d = ry_q + p34;
          end
          5'd9: begin
            mul_a = ps_q[27:0];
            mul_b = ps_q[27:0];
            rx_d = rx_q + p34;
          end
          5'd10: begin
            mul_a = wx[0];
            mul_b = $signed({3'b0, sen_q});
            rad_d = icfd_pkg::ASIN_ONE_SQ - prod_q[51:0];
            root_d = '0;
          end
          5'd11: begin
            mul_a = wx[1];
            mul_b = $signed({3'b0, sen_q});
            if (scale_q && rate_flag_q) begin
              rate_val_d[0] = sc_val[22:0];
            end else if (scale_q) begin
              accel_val_d[0] = sc_val[24:0];
            end
          end
          5'd12: begin
            mul_a = wx[2];
            mul_b = $signed({3'b0, sen_q});
            if (scale_q && rate_flag_q) begin
              rate_val_d[1] = sc_val[22:0];
            end else if (scale_q) begin
              accel_val_d[1] = sc_val[24:0];
            end
          end
          default: begin
            if (scale_q && rate_flag_q) begin
              rate_val_d[2] = sc_val[22:0];
            end else if (scale_q) begin
              accel_val_d[2] = sc_val[24:0];
            end
          end
        endcase
        prod_d = mul_a * mul_b;
        step_d = step_q + 5'd1;
        if (step_q == MUL_LAST) begin
          step_d = '0;
          state_d = icfd_pkg::ST_SQRT;
        end
      end

      icfd_pkg::ST_SQRT: begin
        if (rad_q >= sq_trial) begin
          rad_d = rad_q - sq_trial;
          root_d = (root_q >> 1) + sq_bit;
        end else begin
          root_d = root_q >> 1;
        end
        step_d = step_q + 5'd1;
        if (step_q == SQRT_LAST) begin
          run_d = '0;
          state_d = icfd_pkg::ST_LOAD;
        end
      end

      icfd_pkg::ST_LOAD: begin
        step_d = '0;
        if (run_q == 2'd1 && ps_q >= icfd_pkg::ASIN_ONE_S) begin
          pitch_d = OUT90;
          run_d = 2'd2;
        end else if (run_q == 2'd1 && ps_q <= -icfd_pkg::ASIN_ONE_S) begin
          pitch_d = -OUT90;
          run_d = 2'd2;
        end else if (x_in == '0 && y_in == '0) begin
          cz_d = '0;
          state_d = icfd_pkg::ST_FIN;
        end else begin
          if (x_in < 0) begin
            if (y_in >= 0) begin
              cx_d = y_in;
              cy_d = -x_in;
              cz_d = icfd_pkg::DEG90_Z;
            end else begin
              cx_d = -y_in;
              cy_d = x_in;
              cz_d = -icfd_pkg::DEG90_Z;
            end
          end else begin
            cx_d = x_in;
            cy_d = y_in;
            cz_d = '0;
          end
          state_d = icfd_pkg::ST_NORM;
        end
      end

      icfd_pkg::ST_NORM: begin
        if (ax >= icfd_pkg::NORM_LIMIT || ay >= icfd_pkg::NORM_LIMIT) begin
          step_d = '0;
          state_d = icfd_pkg::ST_ROT;
        end else if (ax < icfd_pkg::COARSE_LIMIT && ay < icfd_pkg::COARSE_LIMIT) begin
          cx_d = cx_q <<< 4;
          cy_d = cy_q <<< 4;
        end else begin
          cx_d = cx_q <<< 1;
          cy_d = cy_q <<< 1;
        end
      end

      icfd_pkg::ST_ROT: begin
        if (cy_q > 0) begin
          cx_d = cx_q + dx;
          cy_d = cy_q - dy;
          cz_d = cz_q + atan_v;
        end else begin
          cx_d = cx_q - dx;
          cy_d = cy_q + dy;
          cz_d = cz_q - atan_v;
        end
        step_d = step_q + 5'd1;
        if (step_q == ROT_LAST) begin
          state_d = icfd_pkg::ST_FIN;
        end
      end

      icfd_pkg::ST_FIN: begin
        case (run_q)
          2'd0: begin
            if (yaw_t < 0) begin
              yaw_d = '0;
            end else if (yaw_t > OUT360) begin
              yaw_d = OUT360;
            end else begin
              yaw_d = yaw_t;
            end
          end
          2'd1: begin
            if (fr > OUT90) begin
              pitch_d = OUT90;
            end else if (fr < -OUT90) begin
              pitch_d = -OUT90;
            end else begin
              pitch_d = fr;
            end
          end
          default: begin
            roll_d = fr;
          end
        endcase
        if (run_q == 2'd2) begin
          state_d = icfd_pkg::ST_DONE;
        end else begin
          run_d = run_q + 2'd1;
          state_d = icfd_pkg::ST_LOAD;
        end
      end

      icfd_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          kind_o_d = kind_q;
          yaw_o_d = yaw_q[24:0];
          pitch_o_d = pitch_q[23:0];
          roll_o_d = roll_q[24:0];
          rate_o_d = rate_val_q;
          accel_o_d = accel_val_q;
          temp_o_d = temp_q;
          stamp_o_d = stamp_q;
          state_d = icfd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = icfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= icfd_pkg::ST_IDLE;
      step_q <= '0;
      run_q <= '0;
      quat_q <= '{default: '0};
      euler_mode_q <= 1'b0;
      rate_sel_q <= '0;
      accel_sel_q <= '0;
      temp_q <= '0;
      stamp_q <= '0;
      rate_val_q <= '{default: '0};
      accel_val_q <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      run_q <= run_d;
      quat_q <= quat_d;
      euler_mode_q <= euler_mode_d;
      rate_sel_q <= rate_sel_d;
      accel_sel_q <= accel_sel_d;
      temp_q <= temp_d;
      stamp_q <= stamp_d;
      rate_val_q <= rate_val_d;
      accel_val_q <= accel_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    scale_q <= scale_d;
    rate_flag_q <= rate_flag_d;
    words_q <= words_d;
    sen_q <= sen_d;
    prod_q <= prod_d;
    yy_q <= yy_d;
    yx_q <= yx_d;
    ps_q <= ps_d;
    ry_q <= ry_d;
    rx_q <= rx_d;
    rad_q <= rad_d;
    root_q <= root_d;
    cx_q <= cx_d;
    cy_q <= cy_d;
    cz_q <= cz_d;
    yaw_q <= yaw_d;
    pitch_q <= pitch_d;
    roll_q <= roll_d;
    kind_o_q <= kind_o_d;
    yaw_o_q <= yaw_o_d;
    pitch_o_q <= pitch_o_d;
    roll_o_q <= roll_o_d;
    rate_o_q <= rate_o_d;
    accel_o_q <= accel_o_d;
    temp_o_q <= temp_o_d;
    stamp_o_q <= stamp_o_d;
  end

  assign in_stall_o     = (state_q != icfd_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign frame_kind_o   = kind_o_q;
  assign yaw_angle_o    = yaw_o_q;
  assign pitch_angle_o  = pitch_o_q;
  assign roll_angle_o   = roll_o_q;
  assign rate_x_o       = rate_o_q[0];
  assign rate_y_o       = rate_o_q[1];
  assign rate_z_o       = rate_o_q[2];
  assign accel_x_o      = accel_o_q[0];
  assign accel_y_o      = accel_o_q[1];
  assign accel_z_o      = accel_o_q[2];
  assign sensor_temp_o  = $signed(temp_o_q);
  assign sensor_stamp_o = stamp_o_q;

endmodule

`default_nettype wire

FILE: hdl/icfd_checker.sv
// icfd_checker: port-level assertions for the imu can frame decoder, with its bind
// depends on icfd_pkg and binds to imu_can_frame_decoder_unit
`default_nettype none

module icfd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] frame_kind_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted transaction keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_kind_o <= icfd_pkg::KIND_IGNORED)
    else $error("frame kind out of range");

endmodule

bind imu_can_frame_decoder_unit icfd_checker u_icfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_kind_o (frame_kind_o)
);

`default_nettype wire
